/* design/rpwc_pkg.sv */
// Package of the ring prefetch window controller: sizes, codes and the result record.
`timescale 1ns / 1ps

package rpwc_pkg;

	localparam int RING_SIZE = 4096;
	localparam int POS_WIDTH = 31;
	localparam int RING_W    = $clog2(RING_SIZE);
	localparam int LEN_W     = RING_W + 1;
	localparam int THR_W     = 12;
	localparam int OP_W      = 2;
	localparam int KIND_W    = 2;

	typedef enum logic [OP_W-1:0] {
		OP_SEEK   = 2'd0,
		OP_REFILL = 2'd1,
		OP_READ   = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_FETCH = 2'd0,
		KIND_READ  = 2'd1,
		KIND_STALL = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	localparam logic CFG_STREAM_LENGTH    = 1'b0;
	localparam logic CFG_REFILL_THRESHOLD = 1'b1;

	typedef struct packed {
		kind_t                kind;
		logic [POS_WIDTH-1:0] spos;
		logic [RING_W-1:0]    rpos;
		logic [LEN_W-1:0]     len;
		logic                 last;
	} res_t;

endpackage

/* design/ring_prefetch_window_controller.sv */
// Top level of the ring prefetch window controller: window state, command stage and result buffer.
`timescale 1ns / 1ps

// Each accepted command is held in one input register and worked out once the buffer allows, which
// updates the window head, tail and read cursor and writes its zero, one or two result transactions
// into a two-entry result buffer. A command is taken from the input register only when the buffer
// will be empty after that cycle, so commands giving at most one result sustain one per cycle while
// res_stall is low, and a command giving two results (a fetch or read split across the ring end)
// blocks the input until its second result is taken. Fetch descriptors advance the tail as soon as
// they are issued, so reads of fetched bytes must wait until the fetches have completed.
// Configuration is written through a plain write port and must only be written while idle.
module ring_prefetch_window_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic                           cfg_index,
	input  logic [rpwc_pkg::POS_WIDTH-1:0] cfg_data,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  logic [rpwc_pkg::OP_W-1:0]      operation,
	input  logic [rpwc_pkg::POS_WIDTH-1:0] seek_position,
	input  logic [rpwc_pkg::LEN_W-1:0]     read_length,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [rpwc_pkg::KIND_W-1:0]    kind,
	output logic [rpwc_pkg::POS_WIDTH-1:0] stream_position,
	output logic [rpwc_pkg::RING_W-1:0]    ring_position,
	output logic [rpwc_pkg::LEN_W-1:0]     length,
	output logic                           last
);

	localparam int PW = rpwc_pkg::POS_WIDTH;
	localparam int RW = rpwc_pkg::RING_W;
	localparam int LW = rpwc_pkg::LEN_W;
	localparam logic [PW-1:0] RS_P = PW'(rpwc_pkg::RING_SIZE);
	localparam logic [LW-1:0] RS_L = LW'(rpwc_pkg::RING_SIZE);
	localparam logic CFG_STREAM_LENGTH_I    = rpwc_pkg::CFG_STREAM_LENGTH;
	localparam logic CFG_REFILL_THRESHOLD_I = rpwc_pkg::CFG_REFILL_THRESHOLD;

	// Configuration and window state
	logic [PW-1:0]                  stream_length_q;
	logic [rpwc_pkg::THR_W-1:0]     refill_threshold_q;
	logic [PW-1:0]                  head_q, tail_q, cursor_q;

	// Input stage
	logic                           valid_s1;
	rpwc_pkg::op_t                  op_s1;
	logic [PW-1:0]                  seek_s1;
	logic [LW-1:0]                  len_s1;

	// Result buffer
	rpwc_pkg::res_t                 res0_q, res1_q;
	logic [1:0]                     cnt_q;

	logic                           pop, go;
	rpwc_pkg::res_t                 new0, new1;
	logic [1:0]                     new_cnt;
	logic [PW-1:0]                  head_d, tail_d, cursor_d;

	// Refill terms
	logic                           outside;
	logic [PW-1:0]                  win_h, win_t, present, left, thresh, fill_p, next_tail;
	logic [LW-1:0]                  fill_l, f_part1;
	logic [RW-1:0]                  f_start;
	logic                           f_cross;

	// Read terms
	logic [LW-1:0]                  len_c, len2, r_part1;
	logic [PW-1:0]                  remain;
	logic [RW-1:0]                  r_start;
	logic                           r_cross, r_miss;

	function automatic logic read_length_gt_ring(input logic [LW-1:0] l);
		return l > RS_L;
	endfunction

	assign pop       = (cnt_q != 2'd0) && !res_stall;
	assign go        = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
	assign cmd_stall = valid_s1 && !go;

	assign res_valid       = (cnt_q != 2'd0);
	assign kind            = res0_q.kind;
	assign stream_position = res0_q.spos;
	assign ring_position   = res0_q.rpos;
	assign length          = res0_q.len;
	assign last            = res0_q.last;

	always_comb begin
		// Refill: the window is dropped when the cursor has left it.
		outside   = (cursor_q < head_q) || (tail_q < cursor_q);
		win_h     = outside ? cursor_q : head_q;
		win_t     = outside ? cursor_q : tail_q;
		present   = win_t - cursor_q;
		left      = stream_length_q - win_t;
		thresh    = (PW'(refill_threshold_q) < left) ? PW'(refill_threshold_q) : left;
		fill_p    = (present < RS_P) ? (RS_P - present) : '0;
		if (fill_p > left) begin
			fill_p = left;
		end
		fill_l    = fill_p[LW-1:0];
		f_start   = win_t[RW-1:0];
		f_cross   = ({2'b00, f_start} + {1'b0, fill_l}) > {1'b0, RS_L};
		f_part1   = RS_L - {1'b0, f_start};
		next_tail = win_t + PW'(fill_l);

		// Read: clamp to the ring size and to the end of the stream.
		len_c   = (read_length_gt_ring(len_s1)) ? RS_L : len_s1;
		remain  = stream_length_q - cursor_q;
		len2    = (PW'(len_c) > remain) ? remain[LW-1:0] : len_c;
		r_miss  = (cursor_q < head_q) ||
			(({1'b0, cursor_q} + (PW+1)'(len2)) > {1'b0, tail_q});
		r_start = cursor_q[RW-1:0];
		r_cross = ({2'b00, r_start} + {1'b0, len2}) > {1'b0, RS_L};
		r_part1 = RS_L - {1'b0, r_start};

		head_d   = head_q;
		tail_d   = tail_q;
		cursor_d = cursor_q;
		new_cnt  = 2'd0;
		new0     = '{kind: rpwc_pkg::KIND_NONE, spos: cursor_q, rpos: r_start,
			len: '0, last: 1'b1};
		new1     = '{kind: rpwc_pkg::KIND_FETCH, spos: '0, rpos: '0, len: '0, last: 1'b1};

		case (op_s1)
			rpwc_pkg::OP_SEEK: begin
				cursor_d = seek_s1;
			end
			rpwc_pkg::OP_REFILL: begin
				head_d = win_h;
				tail_d = win_t;
				if ((win_t < stream_length_q) && (present < thresh) && (fill_l != '0)) begin
					tail_d = next_tail;
					if ((next_tail >= win_h) && ((next_tail - win_h) > RS_P)) begin
						head_d = next_tail - RS_P;
					end
					new0.kind = rpwc_pkg::KIND_FETCH;
					new0.spos = win_t;
					new0.rpos = f_start;
					new0.len  = f_cross ? f_part1 : fill_l;
					new0.last = !f_cross;
					new1.kind = rpwc_pkg::KIND_FETCH;
					new1.spos = win_t + PW'(f_part1);
					new1.len  = fill_l - f_part1;
					new_cnt   = f_cross ? 2'd2 : 2'd1;
				end
			end
			rpwc_pkg::OP_READ: begin
				new_cnt = 2'd1;
				if ((cursor_q >= stream_length_q) || (len2 == '0)) begin
					new0.kind = rpwc_pkg::KIND_NONE;
				end else if (r_miss) begin
					new0.kind = rpwc_pkg::KIND_STALL;
					new0.len  = len2;
				end else begin
					cursor_d  = cursor_q + PW'(len2);
					new0.kind = rpwc_pkg::KIND_READ;
					new0.len  = r_cross ? r_part1 : len2;
					new0.last = !r_cross;
					new1.kind = rpwc_pkg::KIND_READ;
					new1.spos = cursor_q + PW'(r_part1);
					new1.len  = len2 - r_part1;
					new_cnt   = r_cross ? 2'd2 : 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_length_q    <= '0;
			refill_threshold_q <= '0;
			head_q             <= '0;
			tail_q             <= '0;
			cursor_q           <= '0;
			valid_s1           <= 1'b0;
			cnt_q              <= 2'd0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_STREAM_LENGTH_I:    stream_length_q    <= cfg_data;
					CFG_REFILL_THRESHOLD_I: refill_threshold_q <= cfg_data[rpwc_pkg::THR_W-1:0];
					default: begin
					end
				endcase
			end
			if (!cmd_stall) begin
				valid_s1 <= cmd_valid;
			end
			if (go) begin
				head_q   <= head_d;
				tail_q   <= tail_d;
				cursor_q <= cursor_d;
				cnt_q    <= new_cnt;
			end else if (pop) begin
				cnt_q    <= cnt_q - 2'd1;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			op_s1   <= rpwc_pkg::op_t'(operation);
			seek_s1 <= seek_position;
			len_s1  <= read_length;
		end
		if (go) begin
			res0_q <= new0;
			res1_q <= new1;
		end else if (pop) begin
			res0_q <= res1_q;
		end
	end

endmodule
